/* rtl/rmst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range-minimum segment tree block.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 2;

  localparam logic signed [VAL_W-1:0] INT_MAX        = 32'sh7fff_ffff;
  localparam logic [IDX_W-1:0]        LAST_INDEX_RST = 10'd1023;
  localparam logic [APB_AW-1:0]       ADDR_LAST_INDEX = 2'd0;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_UP,
    ST_Q_TEST,
    ST_Q_A,
    ST_Q_B,
    ST_Q_OUT
  } rmst_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new request from the input ports
    logic clr_step;  // clear one node of the tree
    logic wr_leaf;   // write the leaf, read its sibling
    logic wr_up;     // write the parent minimum, read the next sibling
    logic q_a;       // left edge of the current query level
    logic q_b;       // right edge of the current query level, then go up
    logic out_load;  // move the accumulated minimum to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_query;
    logic write_ok;
    logic query_empty;
    logic clr_last;
    logic parent_root;
    logic a_lt_b;
    logic out_busy;
  } dp_status_t;

endpackage

/* rtl/rmst_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_regs
// APB register file holding the highest element index in use.
// ----------------------------------------------------------------------------
module rmst_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmst_pkg::APB_AW-1:0] paddr,
  input  logic [rmst_pkg::APB_DW-1:0] pwdata,
  output logic [rmst_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [rmst_pkg::IDX_W-1:0]  last_index_o
);
  import rmst_pkg::*;

  logic [IDX_W-1:0] last_index_q, last_index_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_LAST_INDEX);

  always_comb begin
    last_index_d = last_index_q;
    if (wr_en) begin
      last_index_d = pwdata[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= LAST_INDEX_RST;
    end else begin
      last_index_q <= last_index_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_LAST_INDEX) begin
      prdata = {{(APB_DW-IDX_W){1'b0}}, last_index_q};
    end
  end

  assign last_index_o = last_index_q;

endmodule

/* rtl/rmst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for the clearing pass, leaf writes and range queries.
// ----------------------------------------------------------------------------
module rmst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rmst_pkg::dp_status_t status_i,
  output rmst_pkg::dp_cmd_t    cmd_o
);
  import rmst_pkg::*;

  rmst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.mode_query) begin
            state_d = status_i.query_empty ? ST_Q_OUT : ST_Q_TEST;
          end else if (status_i.write_ok) begin
            state_d = ST_W_LEAF;
          end
        end
      end
      ST_W_LEAF: begin
        cmd_o.wr_leaf = 1'b1;
        state_d       = ST_W_UP;
      end
      ST_W_UP: begin
        cmd_o.wr_up = 1'b1;
        if (status_i.parent_root) begin
          state_d = ST_IDLE;
        end
      end
      ST_Q_TEST: begin
        state_d = status_i.a_lt_b ? ST_Q_A : ST_Q_OUT;
      end
      ST_Q_A: begin
        cmd_o.q_a = 1'b1;
        state_d   = ST_Q_B;
      end
      ST_Q_B: begin
        cmd_o.q_b = 1'b1;
        state_d   = ST_Q_TEST;
      end
      ST_Q_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/rmst_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_dp
// Tree memory, walk pointers, minimum accumulator and output register.
// ----------------------------------------------------------------------------
module rmst_dp #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmst_pkg::dp_cmd_t                 cmd_i,
  output rmst_pkg::dp_status_t              status_o,
  input  logic [rmst_pkg::IDX_W-1:0]        last_index_i,
  input  logic                              mode_i,
  input  logic [rmst_pkg::IDX_W-1:0]        left_index_i,
  input  logic [rmst_pkg::IDX_W-1:0]        right_index_i,
  input  logic signed [rmst_pkg::VAL_W-1:0] value_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [rmst_pkg::VAL_W-1:0] minimum_o
);
  import rmst_pkg::*;

  localparam int unsigned NODES   = 2 * LEAVES;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned B_W     = $clog2(NODES + 1);
  localparam int unsigned MAX_TOP = (LEAVES - 1 > 1023) ? 1023 : LEAVES - 1;
  localparam logic [IDX_W-1:0]  MAX_TOP_V = IDX_W'(MAX_TOP);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

  logic signed [VAL_W-1:0] mem_q [NODES];
  logic signed [VAL_W-1:0] rdata_q;

  logic [NODE_W-1:0]       clr_q, p_q;
  logic [B_W-1:0]          a_q, b_q, b_dec;
  logic signed [VAL_W-1:0] cur_q, acc_q, minimum_q, cur_min, acc_min;
  logic                    rd_pend_q, out_valid_q;

  logic [IDX_W-1:0]        top, hi_c;
  logic [NODE_W-1:0]       parent;

  logic                    we, re;
  logic [NODE_W-1:0]       waddr, raddr;
  logic signed [VAL_W-1:0] wdata;

  // Usable span and clipped right bound of an incoming request.
  assign top    = (last_index_i > MAX_TOP_V) ? MAX_TOP_V : last_index_i;
  assign hi_c   = (right_index_i > top) ? top : right_index_i;
  assign parent = p_q >> 1;
  assign b_dec  = b_q - B_W'(1);

  assign cur_min = (rdata_q < cur_q) ? rdata_q : cur_q;
  assign acc_min = (rdata_q < acc_q) ? rdata_q : acc_q;

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = p_q;
    wdata = cur_q;
    re    = 1'b0;
    raddr = p_q ^ NODE_W'(1);
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = INT_MAX;
    end else if (cmd_i.wr_leaf) begin
      we = 1'b1;
      re = 1'b1;
    end else if (cmd_i.wr_up) begin
      we    = 1'b1;
      waddr = parent;
      wdata = cur_min;
      re    = 1'b1;
      raddr = parent ^ NODE_W'(1);
    end else if (cmd_i.q_a) begin
      re    = a_q[0];
      raddr = a_q[NODE_W-1:0];
    end else if (cmd_i.q_b) begin
      re    = b_q[0];
      raddr = b_dec[NODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Walk registers and accumulator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q   <= NODE_W'(LEAVES) + NODE_W'(left_index_i);
      a_q   <= B_W'(LEAVES) + B_W'(left_index_i);
      b_q   <= B_W'(LEAVES) + B_W'(hi_c) + B_W'(1);
      cur_q <= value_i;
      acc_q <= INT_MAX;
    end else begin
      if (cmd_i.wr_up) begin
        p_q   <= parent;
        cur_q <= cur_min;
      end
      if (cmd_i.q_a && a_q[0]) begin
        a_q <= a_q + B_W'(1);
      end
      if (cmd_i.q_b) begin
        a_q <= a_q >> 1;
        b_q <= (b_q[0] ? b_dec : b_q) >> 1;
      end
      if (rd_pend_q) begin
        acc_q <= acc_min;
      end
    end
    if (cmd_i.out_load) begin
      minimum_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + NODE_W'(1);
      end
      rd_pend_q <= (cmd_i.q_a && a_q[0]) || (cmd_i.q_b && b_q[0]);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.mode_query  = (mode_i == MODE_QUERY);
  assign status_o.write_ok    = (left_index_i <= top);
  assign status_o.query_empty = (left_index_i > hi_c);
  assign status_o.clr_last    = (clr_q == LAST_NODE);
  assign status_o.parent_root = (parent == ROOT_NODE);
  assign status_o.a_lt_b      = (a_q < b_q);
  assign status_o.out_busy    = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign minimum_o   = minimum_q;

endmodule

/* rtl/range_min_segment_tree_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree_top
// Segment tree of signed 32-bit minima with point writes and range queries.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -------------------------------
//  input     in         in_valid_i / in_stall_o   mode, left_index, right_index,
//                                                 value
//  result    out        out_valid_o / out_stall_i minimum (one per query)
//  config    in         APB psel/penable/pready   last_index at byte address 0
//
//  After reset a clearing pass writes the largest positive value into every
//  node, one node per cycle; no request is taken during the pass, although
//  register writes are accepted as usual.
//  A point write, once accepted, writes the leaf and then each parent on the
//  way up to the root, one tree level at a time, bounded by the single read
//  port that fetches one sibling per level.
//  A query walks up one level at a time: a bound test, then the left and right
//  edge reads (two node reads share the one read port), then an output step;
//  a full-width range walks 11 levels at 1024 leaves.
//  Only one request is in progress at a time. A finished minimum sits in the
//  output register, so a new request is accepted while it waits; a stalled
//  result only holds up the next query when that query is ready to deliver.
//
module range_min_segment_tree_top #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [rmst_pkg::IDX_W-1:0]        left_index_i,
  input  logic [rmst_pkg::IDX_W-1:0]        right_index_i,
  input  logic signed [rmst_pkg::VAL_W-1:0] value_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rmst_pkg::VAL_W-1:0] minimum_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmst_pkg::APB_AW-1:0]       paddr,
  input  logic [rmst_pkg::APB_DW-1:0]       pwdata,
  output logic [rmst_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import rmst_pkg::*;

  logic [IDX_W-1:0] last_index;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // The register file only holds the usable span; it may change between
  // requests and leaves the stored tree untouched.
  rmst_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .last_index_o (last_index)
  );

  // The controller sequences the clearing pass, the walk up from a leaf and
  // the bottom-up query walk, one tree level at a time.
  rmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath owns the node memory, the walk pointers, the running
  // minimum and the output register.
  rmst_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .last_index_i  (last_index),
    .mode_i        (mode_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .minimum_o     (minimum_o)
  );

endmodule

/* rtl/rmst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks of the segment tree block, bound to the top level.
// ----------------------------------------------------------------------------
module rmst_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              mode_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [rmst_pkg::VAL_W-1:0] minimum_o
);
  import rmst_pkg::*;

  // A stalled result stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(minimum_o))
    else $error("stalled result changed or vanished");

  // An accepted query keeps the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_QUERY) |=> in_stall_o)
    else $error("block free directly after accepting a query");

  // A new result only appears while a request was being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

endmodule

bind range_min_segment_tree_top rmst_checker u_rmst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .minimum_o   (minimum_o)
);
